// ----- rtl/uvo_pkg.sv -----
// Shared types and constants for the orthogonal unit vector block.
// No dependencies.
`default_nettype none

package uvo_pkg;

	localparam int FRAC_BITS = 30;
	localparam int QW        = FRAC_BITS + 2;   // quotient width incl. integer bit and round carry
	localparam int SQ_STEPS  = 32;              // result bits of the 64-bit square root
	localparam int QDEPTH    = 4;
	localparam int QPTR_W    = $clog2(QDEPTH);
	localparam logic [63:0] ONE  = 64'd1 << FRAC_BITS;
	localparam logic [4:0]  NORM_MSB = 5'd30;   // direction vector is scaled up to bit 30

	// index of the replaced component
	localparam logic [1:0] IDX_X = 2'd0;
	localparam logic [1:0] IDX_Y = 2'd1;
	localparam logic [1:0] IDX_Z = 2'd2;

	typedef struct packed {
		logic [1:0] m;
		logic       neg_a;
		logic       neg_b;
		logic       deg;
	} meta_t;

	typedef struct packed {
		logic [31:0] a;
		logic [31:0] b;
		logic [4:0]  sh;
		meta_t       meta;
	} qent_t;

	typedef struct packed {
		logic [31:0] a;
		logic [31:0] b;
		meta_t       meta;
	} side_t;

endpackage

`default_nettype wire

// ----- rtl/uvo_front.sv -----
// Front end: picks the least component, forms the two nonzero cross product
// magnitudes, their signs and the normalizing shift. Uses uvo_pkg.
`default_nettype none

module uvo_front (
	input  logic [95:0]   tdata,   // w_x, w_y, w_z from bit 0 up
	output uvo_pkg::qent_t ent
);
	import uvo_pkg::*;

	logic signed [31:0] wx, wy, wz;
	logic [31:0] mag_x, mag_y, mag_z, mag_m;
	logic [1:0]  m;
	logic [63:0] wm64;
	logic        fac_neg;
	logic [4:0]  msb;

	assign wx = tdata[31:0];
	assign wy = tdata[63:32];
	assign wz = tdata[95:64];
	assign mag_x = wx[31] ? (~wx + 32'd1) : wx;
	assign mag_y = wy[31] ? (~wy + 32'd1) : wy;
	assign mag_z = wz[31] ? (~wz + 32'd1) : wz;

	// ties go to the later index
	always_comb begin
		m     = IDX_X;
		mag_m = mag_x;
		if (mag_y <= mag_m) begin
			m     = IDX_Y;
			mag_m = mag_y;
		end
		if (mag_z <= mag_m) begin
			m     = IDX_Z;
			mag_m = mag_z;
		end
	end

	always_comb begin
		ent = '0;
		wm64 = '0;
		unique case (m)
			IDX_X: begin
				wm64 = {{32{wx[31]}}, wx};
				ent.a = mag_z;
				ent.meta.neg_a = !wz[31] && (wz != 32'sd0);
				ent.b = mag_y;
				ent.meta.neg_b = wy[31];
			end
			IDX_Y: begin
				wm64 = {{32{wy[31]}}, wy};
				ent.a = mag_z;
				ent.meta.neg_a = wz[31];
				ent.b = mag_x;
				ent.meta.neg_b = !wx[31] && (wx != 32'sd0);
			end
			IDX_Z: begin
				wm64 = {{32{wz[31]}}, wz};
				ent.a = mag_y;
				ent.meta.neg_a = !wy[31] && (wy != 32'sd0);
				ent.b = mag_x;
				ent.meta.neg_b = wx[31];
			end
			default: begin
				wm64 = '0;
			end
		endcase
		// the factor (1.0 - w_m) flips both signs when negative
		fac_neg = $signed(wm64) > $signed(ONE);
		ent.meta.neg_a = ent.meta.neg_a ^ fac_neg;
		ent.meta.neg_b = ent.meta.neg_b ^ fac_neg;
		ent.meta.m     = m;
		ent.meta.deg   = (wm64 == ONE) || ((ent.a == '0) && (ent.b == '0));
		ent.sh         = (msb < NORM_MSB) ? (NORM_MSB - msb) : 5'd0;
	end

	// leading one of the larger lane
	always_comb begin
		logic [31:0] big;
		if (m == IDX_X)
			big = (mag_z > mag_y) ? mag_z : mag_y;
		else if (m == IDX_Y)
			big = (mag_z > mag_x) ? mag_z : mag_x;
		else
			big = (mag_y > mag_x) ? mag_y : mag_x;
		msb = '0;
		for (int i = 0; i < 32; i++) begin
			if (big[i])
				msb = 5'(i);
		end
	end

endmodule

`default_nettype wire

// ----- rtl/uvo_queue.sv -----
// Short queue between front and back end; each side stalls on its own.
// Uses uvo_pkg.
`default_nettype none

module uvo_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  uvo_pkg::qent_t din,
	input  logic           pop,
	output uvo_pkg::qent_t dout,
	output logic           full,
	output logic           empty
);
	import uvo_pkg::*;

	qent_t                mem_q [0:QDEPTH-1];
	logic [QPTR_W-1:0]    wr_q, rd_q;
	logic [QPTR_W:0]      cnt_q;

	assign full  = (cnt_q == (QPTR_W+1)'(QDEPTH));
	assign empty = (cnt_q == '0);
	assign dout  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= din;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + 1'b1;
			if (pop)
				rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
		end
	end

endmodule

`default_nettype wire

// ----- rtl/uvo_isqrt.sv -----
// Pipelined integer square root, one result bit per stage.
// Uses uvo_pkg.
`default_nettype none

module uvo_isqrt (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           vld_in,
	input  logic [63:0]    rad,
	input  uvo_pkg::side_t side_in,
	output logic           vld_out,
	output logic [32:0]    root,
	output uvo_pkg::side_t side_out
);
	import uvo_pkg::*;

	logic [63:0] x_s   [1:SQ_STEPS];
	logic [63:0] res_s [1:SQ_STEPS];
	logic        vld_s [1:SQ_STEPS];
	side_t       side_s[1:SQ_STEPS];

	for (genvar k = 0; k < SQ_STEPS; k++) begin : g_stage
		localparam logic [63:0] BIT = 64'd1 << (62 - 2*k);
		logic [63:0] x_p, res_p, trial;
		logic        vld_p;
		side_t       side_p;

		if (k == 0) begin : g_first
			assign x_p    = rad;
			assign res_p  = '0;
			assign vld_p  = vld_in;
			assign side_p = side_in;
		end else begin : g_next
			assign x_p    = x_s[k];
			assign res_p  = res_s[k];
			assign vld_p  = vld_s[k];
			assign side_p = side_s[k];
		end

		assign trial = res_p + BIT;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vld_s[k+1] <= 1'b0;
			else if (en)
				vld_s[k+1] <= vld_p;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				side_s[k+1] <= side_p;
				if (x_p >= trial) begin
					x_s[k+1]   <= x_p - trial;
					res_s[k+1] <= (res_p >> 1) + BIT;
				end else begin
					x_s[k+1]   <= x_p;
					res_s[k+1] <= res_p >> 1;
				end
			end
		end
	end

	assign vld_out  = vld_s[SQ_STEPS];
	assign root     = res_s[SQ_STEPS][32:0];
	assign side_out = side_s[SQ_STEPS];

endmodule

`default_nettype wire

// ----- rtl/uvo_sdiv.sv -----
// Pipelined scaled divider for both lanes: round(num * 2^FRAC_BITS / den),
// one quotient bit per stage, then a rounding stage. Uses uvo_pkg.
`default_nettype none

module uvo_sdiv (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           vld_in,
	input  logic [32:0]    den,
	input  uvo_pkg::side_t side_in,
	output logic           vld_out,
	output logic [uvo_pkg::QW-1:0] q_a,
	output logic [uvo_pkg::QW-1:0] q_b,
	output uvo_pkg::meta_t meta_out
);
	import uvo_pkg::*;

	localparam int NS = FRAC_BITS + 1;   // integer stage + fraction steps

	logic [32:0]   den_s  [1:NS];
	logic [32:0]   ra_s   [1:NS];
	logic [32:0]   rb_s   [1:NS];
	logic [QW-1:0] qa_s   [1:NS];
	logic [QW-1:0] qb_s   [1:NS];
	logic          vld_s  [1:NS];
	meta_t         meta_s [1:NS];
	logic          vld_rnd_q;
	logic [QW-1:0] qa_rnd_q, qb_rnd_q;
	meta_t         meta_rnd_q;

	// integer bit: num <= den so it is 0 or 1
	logic ga0, gb0;
	assign ga0 = {1'b0, side_in.a} >= den;
	assign gb0 = {1'b0, side_in.b} >= den;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s[1] <= 1'b0;
		else if (en)
			vld_s[1] <= vld_in;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			den_s[1]  <= den;
			meta_s[1] <= side_in.meta;
			ra_s[1]   <= ga0 ? ({1'b0, side_in.a} - den) : {1'b0, side_in.a};
			rb_s[1]   <= gb0 ? ({1'b0, side_in.b} - den) : {1'b0, side_in.b};
			qa_s[1]   <= QW'(ga0);
			qb_s[1]   <= QW'(gb0);
		end
	end

	for (genvar k = 1; k < NS; k++) begin : g_step
		logic [33:0] ra2, rb2;
		logic        ga, gb;
		assign ra2 = {ra_s[k], 1'b0};
		assign rb2 = {rb_s[k], 1'b0};
		assign ga  = ra2 >= {1'b0, den_s[k]};
		assign gb  = rb2 >= {1'b0, den_s[k]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vld_s[k+1] <= 1'b0;
			else if (en)
				vld_s[k+1] <= vld_s[k];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				den_s[k+1]  <= den_s[k];
				meta_s[k+1] <= meta_s[k];
				ra_s[k+1]   <= ga ? 33'(ra2 - {1'b0, den_s[k]}) : ra2[32:0];
				rb_s[k+1]   <= gb ? 33'(rb2 - {1'b0, den_s[k]}) : rb2[32:0];
				qa_s[k+1]   <= {qa_s[k][QW-2:0], ga};
				qb_s[k+1]   <= {qb_s[k][QW-2:0], gb};
			end
		end
	end

	// halves round away from zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_rnd_q <= 1'b0;
		else if (en)
			vld_rnd_q <= vld_s[NS];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			meta_rnd_q <= meta_s[NS];
			qa_rnd_q   <= qa_s[NS] + QW'({ra_s[NS], 1'b0} >= {1'b0, den_s[NS]});
			qb_rnd_q   <= qb_s[NS] + QW'({rb_s[NS], 1'b0} >= {1'b0, den_s[NS]});
		end
	end

	assign vld_out  = vld_rnd_q;
	assign q_a      = qa_rnd_q;
	assign q_b      = qb_rnd_q;
	assign meta_out = meta_rnd_q;

endmodule

`default_nettype wire

// ----- rtl/uvo_back.sv -----
// Back end: normalizing shift, squares, sum, square root, division, sign
// and placement into the output register. Uses uvo_pkg, uvo_isqrt, uvo_sdiv.
`default_nettype none

module uvo_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           vld_in,
	input  uvo_pkg::qent_t ent,
	output logic           pop,
	output logic           m_tvalid,
	input  logic           m_tready,
	output logic [95:0]    m_tdata,
	output logic           m_tuser
);
	import uvo_pkg::*;

	logic          en;
	logic          vld_s1, vld_s2, vld_s3;
	logic [31:0]   a_s1, b_s1, a_s2, b_s2;
	meta_t         meta_s1, meta_s2;
	logic [63:0]   sqa_s2, sqb_s2;
	logic [63:0]   sum_s3;
	side_t         side_s3, side_sq;
	logic          vld_sq, vld_dv;
	logic [32:0]   root;
	logic [QW-1:0] qa, qb;
	meta_t         meta_dv;
	logic [63:0]   ea, eb;
	logic [31:0]   sa, sb;
	logic [95:0]   data_nx;
	logic          out_vld_q;
	logic [95:0]   data_q;
	logic          deg_q;

	// whole back end advances together unless the output item is held
	assign en  = !out_vld_q || m_tready;
	assign pop = en && vld_in;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_in;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1    <= ent.a << ent.sh;
			b_s1    <= ent.b << ent.sh;
			meta_s1 <= ent.meta;
			sqa_s2  <= a_s1 * a_s1;
			sqb_s2  <= b_s1 * b_s1;
			a_s2    <= a_s1;
			b_s2    <= b_s1;
			meta_s2 <= meta_s1;
			sum_s3  <= sqa_s2 + sqb_s2;
			side_s3 <= '{a: a_s2, b: b_s2, meta: meta_s2};
		end
	end

	uvo_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.vld_in   (vld_s3),
		.rad      (sum_s3),
		.side_in  (side_s3),
		.vld_out  (vld_sq),
		.root     (root),
		.side_out (side_sq)
	);

	uvo_sdiv u_sdiv (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.vld_in   (vld_sq),
		.den      (root),
		.side_in  (side_sq),
		.vld_out  (vld_dv),
		.q_a      (qa),
		.q_b      (qb),
		.meta_out (meta_dv)
	);

	assign ea = 64'(qa);
	assign eb = 64'(qb);
	assign sa = meta_dv.neg_a ? 32'(~ea + 64'd1) : ea[31:0];
	assign sb = meta_dv.neg_b ? 32'(~eb + 64'd1) : eb[31:0];

	always_comb begin
		data_nx = '0;
		unique case (meta_dv.m)
			IDX_X:   data_nx = {sb, sa, 32'd0};
			IDX_Y:   data_nx = {sb, 32'd0, sa};
			IDX_Z:   data_nx = {32'd0, sb, sa};
			default: data_nx = '0;
		endcase
		if (meta_dv.deg)
			data_nx = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_vld_q <= 1'b0;
		else if (en)
			out_vld_q <= vld_dv;
	end

	always_ff @(posedge clk) begin
		if (en && vld_dv) begin
			data_q <= data_nx;
			deg_q  <= meta_dv.deg;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = data_q;
	assign m_tuser  = deg_q;

endmodule

`default_nettype wire

// ----- rtl/unit_vector_orthonormal_unit.sv -----
// Top level of the orthogonal unit vector block: front end, queue, back end.
// Uses uvo_pkg, uvo_front, uvo_queue, uvo_back.
`default_nettype none

// Takes a 3D vector w in signed Q2.30 and returns a unit vector u orthogonal
// to it, also Q2.30, with a degenerate flag on tuser when the cross product
// or 1.0 - w_m is zero (u is then all zeros). One item is accepted per
// cycle when the queue has room; the result passes through 3 setup stages,
// 32 square root stages, 31 divider stages, rounding and the output register,
// and the back pipeline holds while an output item waits to be taken.
module unit_vector_orthonormal_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [95:0] s_tdata,   // w_x[31:0], w_y[63:32], w_z[95:64]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [95:0] m_tdata,   // u_x[31:0], u_y[63:32], u_z[95:64]
	output logic        m_tuser    // degenerate
);
	import uvo_pkg::*;

	qent_t ent_in, ent_out;
	logic  full, empty, push, pop;

	assign s_tready = !full;
	assign push     = s_tvalid && !full;

	uvo_front u_front (
		.tdata (s_tdata),
		.ent   (ent_in)
	);

	uvo_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (ent_in),
		.pop    (pop),
		.dout   (ent_out),
		.full   (full),
		.empty  (empty)
	);

	uvo_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.vld_in   (!empty),
		.ent      (ent_out),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule

`default_nettype wire

// ----- rtl/uvo_checker.sv -----
// Port-level checks for the orthogonal unit vector block, bound to the top.
// No package dependency.
`default_nettype none

module uvo_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        s_tvalid,
	input wire        s_tready,
	input wire [95:0] s_tdata,
	input wire        m_tvalid,
	input wire        m_tready,
	input wire [95:0] m_tdata,
	input wire        m_tuser
);

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("output item dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
		else $error("output item changed while stalled");

	a_deg_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata == 96'd0)
		else $error("degenerate item with nonzero vector");

	a_unit_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata != 96'd0)
		else $error("normal item with zero vector");

endmodule

bind unit_vector_orthonormal_unit uvo_checker u_chk (.*);

`default_nettype wire

// ----- dv/tb_top.sv -----
// Testbench for unit_vector_orthonormal_unit: directed and random vectors, checked
// against an in-bench fixed-point predictor. Depends on uvo_pkg and the block RTL.
module tb_top;
	import uvo_pkg::*;

	typedef struct packed {
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] z;
		logic        deg;
	} uvec_t;

	localparam int WATCHDOG = 4000;
	localparam int LATENCY  = 80;
	localparam logic [31:0] P1 = 32'h4000_0000;
	localparam logic [31:0] M1 = 32'hC000_0000;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [95:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [95:0] m_tdata;
	logic        m_tuser;

	uvec_t ortho_q[$];
	int    fails;
	int    idle_cycles;

	unit_vector_orthonormal_unit u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	function automatic logic [63:0] abs64(logic signed [63:0] v);
		return v < 0 ? -v : v;
	endfunction

	function automatic logic [63:0] sqrt_floor(logic [63:0] x);
		logic [63:0] res;
		logic [63:0] bitv;
		res  = 0;
		bitv = 64'd1 << 62;
		while (bitv > x)
			bitv = bitv >> 2;
		while (bitv != 0) begin
			if (x >= res + bitv) begin
				x   = x - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res;
	endfunction

	function automatic logic [63:0] frac_div(logic [63:0] num, logic [63:0] den);
		logic [63:0] q;
		logic [63:0] r;
		q = num / den;
		r = num % den;
		for (int k = 0; k < FRAC_BITS; k++) begin
			r = r << 1;
			q = q << 1;
			if (r >= den) begin
				r = r - den;
				q[0] = 1'b1;
			end
		end
		if (2 * r >= den)
			q = q + 1;
		return q;
	endfunction

	function automatic uvec_t predict_ortho(logic [95:0] d);
		logic signed [63:0] w[3];
		logic signed [63:0] v[3];
		logic [63:0] mg[3];
		logic [63:0] mx, sum, n, q;
		logic signed [63:0] fac;
		logic [31:0] o[3];
		int m;
		uvec_t r;
		for (int i = 0; i < 3; i++)
			w[i] = $signed(d[32*i +: 32]);
		m = 0;
		for (int i = 1; i < 3; i++)
			if (abs64(w[i]) <= abs64(w[m]))
				m = i;
		case (m)
			IDX_X: begin v[0] = 0; v[1] = -w[2]; v[2] = w[1]; end
			IDX_Y: begin v[0] = w[2]; v[1] = 0; v[2] = -w[0]; end
			default: begin v[0] = -w[1]; v[1] = w[0]; v[2] = 0; end
		endcase
		fac = $signed(ONE) - w[m];
		mx = 0;
		for (int i = 0; i < 3; i++) begin
			mg[i] = abs64(v[i]);
			if (mg[i] > mx)
				mx = mg[i];
		end
		if (fac == 0 || mx == 0) begin
			r = '{x: 0, y: 0, z: 0, deg: 1'b1};
			return r;
		end
		while (mx < (64'd1 << 30)) begin
			mx = mx << 1;
			for (int i = 0; i < 3; i++)
				mg[i] = mg[i] << 1;
		end
		sum = 0;
		for (int i = 0; i < 3; i++)
			sum = sum + mg[i] * mg[i];
		n = sqrt_floor(sum);
		for (int i = 0; i < 3; i++) begin
			q = frac_div(mg[i], n);
			if ((v[i] < 0) != (fac < 0))
				q = -q;
			o[i] = q[31:0];
		end
		r = '{x: o[0], y: o[1], z: o[2], deg: 1'b0};
		return r;
	endfunction

	task automatic send_item(logic [31:0] wx, logic [31:0] wy, logic [31:0] wz);
		int gap;
		gap = $urandom_range(0, 5);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tdata  <= {wz, wy, wx};
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		ortho_q.push_back(predict_ortho({wz, wy, wx}));
		@(negedge clk);
	endtask

	task automatic drain;
		s_tvalid <= 1'b0;
		while (ortho_q.size() != 0)
			@(negedge clk);
		repeat (LATENCY) @(negedge clk);
	endtask

	task automatic test_axes;
		logic [31:0] vals[5];
		vals = '{P1, M1, 32'd0, 32'h7FFF_FFFF, 32'h8000_0000};
		foreach (vals[i]) begin
			send_item(vals[i], 32'd0, 32'd0);
			send_item(32'd0, vals[i], 32'd0);
			send_item(32'd0, 32'd0, vals[i]);
		end
		// least component equal to one, ties, all-equal and beyond-one inputs
		send_item(P1, P1, P1);
		send_item(M1, M1, M1);
		send_item(32'd5, 32'd5, 32'd7);
		send_item(32'h2D41_3CCD, 32'hD2BE_C333, 32'h2D41_3CCD);
		send_item(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		send_item(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0001);
		send_item(32'd1, 32'hFFFF_FFFF, 32'd0);
		send_item(32'h2000_0000, 32'h3000_0000, 32'h2000_0000);
		drain();
	endtask

	task automatic test_random_unit;
		real a, b, c, nrm;
		repeat (1300) begin
			a = $itor($signed($urandom)) / 2147483648.0;
			b = $itor($signed($urandom)) / 2147483648.0;
			c = $itor($signed($urandom)) / 2147483648.0;
			nrm = $sqrt(a*a + b*b + c*c);
			if (nrm < 1e-6)
				nrm = 1.0;
			send_item($rtoi(a / nrm * 1073741824.0), $rtoi(b / nrm * 1073741824.0),
				$rtoi(c / nrm * 1073741824.0));
		end
		drain();
	endtask

	task automatic test_random_raw;
		repeat (450) begin
			case ($urandom_range(0, 2))
				0: send_item($urandom, $urandom, $urandom);
				1: send_item($urandom_range(0, 16) - 8, $urandom_range(0, 16) - 8,
					$urandom_range(0, 16) - 8);
				default: send_item($urandom_range(0, 1) ? P1 : M1, $urandom, $urandom);
			endcase
		end
		drain();
	endtask

	// sink: random stall per item, check against oldest prediction
	initial begin
		int stall;
		uvec_t exp_v;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			stall = $urandom_range(0, 5);
			if ($urandom_range(0, 3) == 0)
				stall = 0;
			if (stall != 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid)
				@(posedge clk);
			if (ortho_q.size() == 0) begin
				$error("result with no prediction pending");
				fails++;
			end else begin
				exp_v = ortho_q.pop_front();
				if (m_tdata[31:0] !== exp_v.x) begin
					$error("u_x exp %h got %h", exp_v.x, m_tdata[31:0]);
					fails++;
				end
				if (m_tdata[63:32] !== exp_v.y) begin
					$error("u_y exp %h got %h", exp_v.y, m_tdata[63:32]);
					fails++;
				end
				if (m_tdata[95:64] !== exp_v.z) begin
					$error("u_z exp %h got %h", exp_v.z, m_tdata[95:64]);
					fails++;
				end
				if (m_tuser !== exp_v.deg) begin
					$error("degenerate exp %b got %b", exp_v.deg, m_tuser);
					fails++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		arst_n      = 1'b0;
		s_tvalid    = 1'b0;
		s_tdata     = '0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_axes();
		test_random_unit();
		test_random_raw();
		if (fails == 0 && ortho_q.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end
endmodule

// ----- sim.f -----
rtl/uvo_pkg.sv
rtl/uvo_front.sv
rtl/uvo_queue.sv
rtl/uvo_isqrt.sv
rtl/uvo_sdiv.sv
rtl/uvo_back.sv
rtl/unit_vector_orthonormal_unit.sv
rtl/uvo_checker.sv
dv/tb_top.sv
